>>> src/bbs_pkg.sv
// shared types and constants for the breakpoint side predicate
`timescale 1ns / 1ps
package bbs_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;

  typedef enum logic [1:0] {
    REL_AT    = 2'd0,
    REL_RIGHT = 2'd1,
    REL_LEFT  = 2'd2
  } rel_t;

  typedef enum logic [2:0] {
    CASE_KI  = 3'd0,
    CASE_KJ  = 3'd1,
    CASE_EQY = 3'd2,
    CASE_EQX = 3'd3,
    CASE_GEN = 3'd4
  } br_t;

  function automatic rel_t ord2rel(input logic eq, input logic gt);
    if (eq) return REL_AT;
    return gt ? REL_RIGHT : REL_LEFT;
  endfunction

endpackage

>>> src/bbs_if.sv
// valid/ready channel interface
`timescale 1ns / 1ps
interface bbs_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/bbs_front.sv
// front part: operand differences, branch selection and first products
`timescale 1ns / 1ps
module bbs_front
  import bbs_pkg::*;
#(
  parameter int unsigned CB = COORD_BITS_DEF,
  localparam int unsigned DW = CB + 2,
  localparam int unsigned PW = 2 * DW + 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CB-1:0] xi, yi, xj, yj, xk, yk,
  output logic                 f_valid,
  input  logic                 f_ready,
  output br_t                  f_br,
  output rel_t                 f_rel,
  output logic                 f_bad,
  output logic                 f_flip,
  output logic                 f_yigt,
  output logic signed [DW-1:0] f_q, f_p, f_dxi, f_dxj,
  output logic signed [PW-1:0] f_a, f_b, f_c
);
  logic signed [DW-1:0] p, q, dxi, dxj, t, s, two_xk, sum_x;
  logic signed [PW-1:0] a, b, cc;
  br_t br;
  rel_t rel;

  always_comb begin
    p = DW'(yi) - DW'(yk);
    q = DW'(yj) - DW'(yk);
    dxi = DW'(xk) - DW'(xi);
    dxj = DW'(xk) - DW'(xj);
    t = DW'(yi) - DW'(yj);
    s = DW'(yi) + DW'(yj) - (DW'(yk) <<< 1);
    two_xk = DW'(xk) <<< 1;
    sum_x = DW'(xi) + DW'(xj);
    rel = REL_AT;
    a = '0;
    b = '0;
    cc = '0;
    if (yi == yk) begin
      br = CASE_KI;
      rel = ord2rel(xi == xk, xk > xi);
    end else if (yj == yk) begin
      br = CASE_KJ;
      rel = ord2rel(xj == xk, xk > xj);
    end else if (yi == yj) begin
      br = CASE_EQY;
      rel = ord2rel(sum_x == two_xk, two_xk > sum_x);
    end else if (xi == xj) begin
      br = CASE_EQX;
      a = PW'(s) * PW'(s);
      b = PW'(t) * PW'(t);
      cc = (PW'(dxi) * PW'(dxi)) <<< 2;
    end else begin
      br = CASE_GEN;
      a = PW'(dxi) * PW'(dxi);
      b = PW'(dxj) * PW'(dxj);
      cc = PW'(t) * PW'(p);
    end
  end

  assign in_ready = !f_valid || f_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid <= 1'b0;
    end else if (in_ready) begin
      f_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      f_br <= br;
      f_rel <= rel;
      f_bad <= (yi == yj) && !(xi < xj);
      f_flip <= p[DW-1] != q[DW-1];
      f_yigt <= yi > yj;
      f_q <= q;
      f_p <= p;
      f_dxi <= dxi;
      f_dxj <= dxj;
      f_a <= a;
      f_b <= b;
      f_c <= cc;
    end
  end
endmodule

>>> src/bbs_back.sv
// back part: cross products and final decision
`timescale 1ns / 1ps
module bbs_back
  import bbs_pkg::*;
#(
  parameter int unsigned CB = COORD_BITS_DEF,
  localparam int unsigned DW = CB + 2,
  localparam int unsigned PW = 2 * DW + 2,
  localparam int unsigned XW = PW + DW + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 f_valid,
  output logic                 f_ready,
  input  br_t                  f_br,
  input  rel_t                 f_rel,
  input  logic                 f_bad,
  input  logic                 f_flip,
  input  logic                 f_yigt,
  input  logic signed [DW-1:0] f_q, f_p, f_dxi, f_dxj,
  input  logic signed [PW-1:0] f_a, f_b, f_c,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rel_t                 out_relation,
  output logic                 out_bad
);
  logic signed [PW-1:0] lhs, dk2;
  logic signed [XW-1:0] m1, m2;
  logic c_eq, c_gt, c_lt, kgt_i, klt_i, klt_j;
  rel_t rel;

  always_comb begin
    lhs = f_a + f_c;
    dk2 = f_b + f_c;
    m1 = XW'(lhs) * XW'(f_q);
    m2 = XW'(f_b) * XW'(f_p);
    c_eq = m1 == m2;
    c_gt = f_flip ? (m1 < m2) : (m1 > m2);
    c_lt = !c_eq && !c_gt;
    kgt_i = f_dxi > 0;
    klt_i = f_dxi < 0;
    klt_j = f_dxj < 0;
    rel = f_rel;
    case (f_br)
      CASE_EQX: begin
        if (kgt_i && f_yigt) rel = REL_RIGHT;
        else if (klt_i && !f_yigt) rel = REL_LEFT;
        else if (kgt_i) rel = ord2rel(f_a == dk2, dk2 > f_a);
        else rel = ord2rel(f_a == dk2, f_a > dk2);
      end
      CASE_GEN: begin
        if (f_yigt) begin
          if (c_eq) rel = klt_j ? REL_AT : REL_RIGHT;
          else if (c_gt) rel = REL_RIGHT;
          else rel = klt_j ? REL_LEFT : REL_RIGHT;
        end else begin
          if (c_eq) rel = kgt_i ? REL_AT : REL_RIGHT;
          else if (c_lt) rel = REL_LEFT;
          else rel = klt_i ? REL_LEFT : REL_RIGHT;
        end
      end
      default: rel = f_rel;
    endcase
  end

  assign f_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (f_ready) begin
      out_valid <= f_valid;
    end
    if (f_valid && f_ready) begin
      out_relation <= rel;
      out_bad <= f_bad;
    end
  end

`ifndef NO_ASSERTIONS
  a_rel_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_relation != 2'd3)) else $error("illegal relation");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_relation))
    else $error("result dropped");
  a_bad_eqy: assert property (@(posedge clk) disable iff (!rst_n)
    f_valid && f_bad |-> (f_br != CASE_EQX && f_br != CASE_GEN))
    else $error("flag outside equal height");
`endif
endmodule

>>> src/beachline_breakpoint_side.sv
// top level of the beach-line breakpoint side predicate
`timescale 1ns / 1ps
// Takes one beat per cycle unless the receiver stalls; each beat is registered
// in the front stage and then in the back stage. The front stage forms differences
// and first products, the back stage does the cross multiplication and decision;
// each stage holds a register so either side may stall without losing throughput.
module beachline_breakpoint_side
  import bbs_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_site_i_x,
  input  logic signed [COORD_BITS-1:0] in_site_i_y,
  input  logic signed [COORD_BITS-1:0] in_site_j_x,
  input  logic signed [COORD_BITS-1:0] in_site_j_y,
  input  logic signed [COORD_BITS-1:0] in_site_k_x,
  input  logic signed [COORD_BITS-1:0] in_site_k_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_relation,
  output logic                         out_precondition_bad
);
  localparam int unsigned DW = COORD_BITS + 2;
  localparam int unsigned PW = 2 * DW + 2;

  logic f_valid, f_ready, f_bad, f_flip, f_yigt;
  br_t f_br;
  rel_t f_rel, rel;
  logic signed [DW-1:0] f_q, f_p, f_dxi, f_dxj;
  logic signed [PW-1:0] f_a, f_b, f_c;

  bbs_front #(.CB(COORD_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready,
    .xi(in_site_i_x), .yi(in_site_i_y), .xj(in_site_j_x),
    .yj(in_site_j_y), .xk(in_site_k_x), .yk(in_site_k_y),
    .f_valid, .f_ready, .f_br, .f_rel, .f_bad, .f_flip, .f_yigt,
    .f_q, .f_p, .f_dxi, .f_dxj, .f_a, .f_b, .f_c
  );

  bbs_back #(.CB(COORD_BITS)) u_back (
    .clk, .rst_n, .f_valid, .f_ready, .f_br, .f_rel, .f_bad, .f_flip,
    .f_yigt, .f_q, .f_p, .f_dxi, .f_dxj, .f_a, .f_b, .f_c,
    .out_valid, .out_ready, .out_relation(rel), .out_bad(out_precondition_bad)
  );

  assign out_relation = rel;
endmodule

>>> tb/bbs_tb_pkg.sv
// beat types and prediction of the breakpoint side predicate
`timescale 1ns / 1ps
package bbs_tb_pkg;
  import bbs_pkg::*;

  localparam int unsigned CW = COORD_BITS_DEF;

  typedef struct packed {
    logic signed [CW-1:0] ix;
    logic signed [CW-1:0] iy;
    logic signed [CW-1:0] jx;
    logic signed [CW-1:0] jy;
    logic signed [CW-1:0] kx;
    logic signed [CW-1:0] ky;
  } sites_t;

  typedef struct packed {
    rel_t relation;
    logic precondition_bad;
  } side_t;

  function automatic rel_t rel_of(input longint a, input longint b);
    if (a == b) return REL_AT;
    return (b > a) ? REL_RIGHT : REL_LEFT;
  endfunction

  function automatic side_t breakpoint_side(input sites_t s);
    longint xi, yi, xj, yj, xk, yk;
    longint p, q, a, b, lhs, sm, t, dx, d2, dk2;
    logic signed [127:0] m1, m2, diff;
    int c;
    side_t r;
    xi = s.ix; yi = s.iy; xj = s.jx; yj = s.jy; xk = s.kx; yk = s.ky;
    r.precondition_bad = (yi == yj) && !(xi < xj);
    if (yi == yk) r.relation = rel_of(xi, xk);
    else if (yj == yk) r.relation = rel_of(xj, xk);
    else if (yi == yj) r.relation = rel_of(xi + xj, 2 * xk);
    else if (xi == xj) begin
      if (xk > xi && yi > yj) r.relation = REL_RIGHT;
      else if (xk < xi && yi < yj) r.relation = REL_LEFT;
      else begin
        sm = yi + yj - 2 * yk;
        t = yi - yj;
        dx = xi - xk;
        d2 = sm * sm;
        dk2 = t * t + 4 * dx * dx;
        r.relation = (xk > xi) ? rel_of(d2, dk2) : rel_of(dk2, d2);
      end
    end else begin
      p = yi - yk;
      q = yj - yk;
      a = (xk - xi) * (xk - xi);
      b = (xk - xj) * (xk - xj);
      lhs = a + (yi - yj) * p;
      m1 = 128'(signed'(lhs)) * 128'(signed'(q));
      m2 = 128'(signed'(b)) * 128'(signed'(p));
      diff = m1 - m2;
      c = (diff < 0) ? -1 : ((diff == 0) ? 0 : 1);
      if ((p < 0) != (q < 0)) c = -c;
      if (yi > yj) begin
        if (c == 0) r.relation = (xk < xj) ? REL_AT : REL_RIGHT;
        else if (c > 0) r.relation = REL_RIGHT;
        else r.relation = (xk < xj) ? REL_LEFT : REL_RIGHT;
      end else begin
        if (c == 0) r.relation = (xk > xi) ? REL_AT : REL_RIGHT;
        else if (c < 0) r.relation = REL_LEFT;
        else r.relation = (xk < xi) ? REL_LEFT : REL_RIGHT;
      end
    end
    return r;
  endfunction

endpackage

>>> tb/bbs_checker.sv
// checker that predicts each result beat and compares it
`timescale 1ns / 1ps
module bbs_checker
  import bbs_pkg::*;
  import bbs_tb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  bbs_if       in_ch,
  bbs_if       out_ch,
  output int   fail_count,
  output int   pending
);
  side_t side_q[$];
  int    errs = 0;

  assign fail_count = errs;
  assign pending = side_q.size();

  always @(posedge clk) begin
    side_t exp_side;
    side_t got;
    int    bad;
    bad = 0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) side_q.push_back(breakpoint_side(in_ch.data));
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (side_q.size() == 0) begin
          $error("result beat with nothing expected");
          bad++;
        end else begin
          exp_side = side_q.pop_front();
          if (got.relation !== exp_side.relation) begin
            $error("relation expected %0d actual %0d", exp_side.relation, got.relation);
            bad++;
          end
          if (got.precondition_bad !== exp_side.precondition_bad) begin
            $error("precondition_bad expected %0b actual %0b",
                   exp_side.precondition_bad, got.precondition_bad);
            bad++;
          end
        end
      end
    end
    if (bad != 0) errs <= errs + bad;
  end
endmodule

>>> tb/tb.sv
// testbench top: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps
module tb;
  import bbs_pkg::*;
  import bbs_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  bit   hold_off = 1'b0;

  bbs_if #(.payload_t(sites_t)) in_ch ();
  bbs_if #(.payload_t(side_t))  out_ch ();

  always #5 clk = ~clk;

  beachline_breakpoint_side dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_ch.valid),
    .in_ready            (in_ch.ready),
    .in_site_i_x         (in_ch.data.ix),
    .in_site_i_y         (in_ch.data.iy),
    .in_site_j_x         (in_ch.data.jx),
    .in_site_j_y         (in_ch.data.jy),
    .in_site_k_x         (in_ch.data.kx),
    .in_site_k_y         (in_ch.data.ky),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_relation        (out_ch.data.relation),
    .out_precondition_bad(out_ch.data.precondition_bad)
  );

  bbs_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // receiver: own stall pattern plus one long hold-off
  always @(posedge clk) begin
    int mode;
    if (hold_off) out_ch.ready <= 1'b0;
    else begin
      mode = ($urandom_range(0, 9) < 3) ? 1 : 0;
      out_ch.ready <= (mode == 0) ? 1'b1 : ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    int stall_cycles;
    wait (rst_n);
    repeat (60) @(posedge clk);
    hold_off <= 1'b1;
    for (stall_cycles = 0; stall_cycles < 300; stall_cycles++) @(posedge clk);
    hold_off <= 1'b0;
  end

  function automatic logic signed [CW-1:0] rnd_coord();
    return CW'($urandom);
  endfunction

  function automatic logic signed [CW-1:0] near_coord();
    return CW'($urandom_range(0, 40)) - CW'(20);
  endfunction

  function automatic sites_t random_sites();
    sites_t s;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      s = {rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
    end else begin
      s = {near_coord(), near_coord(), near_coord(), near_coord(), near_coord(), near_coord()};
    end
    case ($urandom_range(0, 7))
      0: s.ky = s.iy;
      1: s.ky = s.jy;
      2: s.jy = s.iy;
      3: s.jx = s.ix;
      4: begin s.jy = s.iy; s.jx = s.ix; end
      default: ;
    endcase
    return s;
  endfunction

  sites_t directed_q[$];
  int burst_left = 0;

  task automatic send(input sites_t s);
    in_ch.valid <= 1'b1;
    in_ch.data <= s;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 30);
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  initial begin
    localparam logic signed [CW-1:0] MX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] MN = {1'b1, {(CW-1){1'b0}}};
    int n;
    directed_q = '{
      '{MX, MX, MX, MX, MX, MX}, '{MN, MN, MN, MN, MN, MN},
      '{MN, MX, MX, MN, 0, 0},   '{MX, MN, MN, MX, MN, MX},
      '{-5, 10, 5, 3, 2, 10},    '{-5, 10, 5, 3, 7, 3},
      '{-4, 10, 6, 10, 1, 0},    '{-4, 10, 6, 10, 2, 0},
      '{6, 10, -4, 10, 1, 0},    '{3, 10, 3, 10, 3, 0},
      '{0, 10, 0, 4, 5, 0},      '{0, 4, 0, 10, -5, 0},
      '{0, 10, 0, 4, -3, 0},     '{0, 4, 0, 10, 3, 0},
      '{0, 10, 0, 4, 0, 0},      '{-6, 8, 7, 3, 1, -2},
      '{-6, 3, 7, 8, 1, -2},     '{-6, 3, 7, 8, 1, 20},
      '{0, 2, 4, 2, 2, 0},       '{MN, 1, MX, -1, 0, MN},
      '{MX, -1, MN, 1, MN, MX},  '{1, 5, -1, 5, 0, -7}
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_q[d]) send(directed_q[d]);
    for (n = 0; n < 1000; n++) send(random_sites());
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("beachline_breakpoint_side verification clean");
    else $display("beachline_breakpoint_side verification failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("beachline_breakpoint_side verification failed");
    $finish;
  end
endmodule
